FILE: sv/vsm_pkg.sv
// Shared constants for the vector similarity metrics block.
// No dependencies; imported by vector_similarity_metrics.
package vsm_pkg;

    localparam int MAX_LEN_DEF = 256;

    // APB map: one 32-bit register, word index in paddr[2]
    localparam int ADDR_W = 3;
    localparam logic REG_THR = 1'b0;
    localparam logic [31:0] THR_RESET = 32'd1;

    // Step counter covers the longest serial pass (den shift of up to 78)
    localparam int STEP_W = 7;

    localparam logic [63:0] SQRT_BIT0 = 64'h4000_0000_0000_0000;
    localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

endpackage

FILE: sv/vector_similarity_metrics.sv
// Vector similarity metrics: Euclidean distance, Pearson correlation, cosine; uses vsm_pkg.
// A new pair is taken only from idle, once the previous pair's multiply-accumulate on the
// shared 32x32 multiplier is done (busy is high meanwhile). The closing pair adds product
// setup and square root, then per ratio (normalize, 32-step square roots, serial shifts,
// 30-step divide); o_valid strobes once both ratios are done.
// Results cannot be stalled. Reset (synchronous, i_rst_n low): sums cleared, threshold = 1.
module vector_similarity_metrics import vsm_pkg::*; #(
    parameter int MAX_LEN = MAX_LEN_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // command side
    input  logic                start,
    output logic                busy,
    input  logic [23:0]         i_first_value,
    input  logic [23:0]         i_second_value,
    input  logic                i_last_pair,
    // result side
    output logic                o_valid,
    output logic [27:0]         o_euclid_distance,
    output logic signed [31:0]  o_pearson_corr,
    output logic signed [31:0]  o_cosine_sim,
    output logic                o_corr_degenerate,
    output logic                o_cos_degenerate,
    // configuration
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    localparam int CNT_W = $clog2(MAX_LEN + 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_ACC,
        S_PREP,
        S_EUC,
        S_CHK,
        S_NORM_A,
        S_NORM_B,
        S_SQRT_A,
        S_SQRT_B,
        S_DEN,
        S_DSHIFT,
        S_NSHIFT,
        S_DIV,
        S_RDONE
    } t_state;

    t_state              r_state;
    logic [STEP_W-1:0]   r_step;

    logic [31:0]         r_thr;

    // running sums
    logic [CNT_W-1:0]    r_cnt;
    logic [31:0]         r_sx;
    logic [31:0]         r_sy;
    logic [55:0]         r_sxy;
    logic [55:0]         r_sxx;
    logic [55:0]         r_syy;
    logic [55:0]         r_sdd;

    // current pair
    logic [23:0]         r_x;
    logic [23:0]         r_y;
    logic [23:0]         r_d;
    logic                r_last;

    // shared multiplier
    logic                mul_en;
    logic [31:0]         mul_a;
    logic [31:0]         mul_b;
    logic [63:0]         r_prod;

    // ratio datapath
    logic [63:0]         r_p;
    logic [63:0]         r_a;
    logic [63:0]         r_b;
    logic [63:0]         r_mag;
    logic                r_neg;
    logic                r_cos_pass;
    logic [4:0]          r_ka;
    logic [4:0]          r_kb;
    logic [31:0]         r_sa;
    logic [31:0]         r_sb;
    logic [63:0]         r_den;
    logic                r_ovf;
    logic                r_flag;
    logic [30:0]         r_q;

    // square root unit
    logic [63:0]         r_w;
    logic [63:0]         r_res;
    logic [63:0]         r_bit;
    logic [63:0]         sq_sum;
    logic                sq_ge;
    logic [63:0]         n_sq_w;
    logic [63:0]         n_sq_res;

    // outputs
    logic                r_valid;
    logic [27:0]         r_euc;
    logic [31:0]         r_pear;
    logic                r_pflag;
    logic [31:0]         r_cos;
    logic                r_kflag;

    // misc combinational
    logic [64:0]         pq_diff;
    logic [63:0]         qp_diff;
    logic [63:0]         pq_pos;
    logic [5:0]          k_sum;
    logic [STEP_W-1:0]   s_den;
    logic [63:0]         dv_sh;
    logic                dv_take;
    logic [31:0]         q_mag;
    logic [31:0]         q_signed;
    logic                cfg_wr;

    assign busy    = (r_state != S_IDLE);
    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite & (paddr[2] == REG_THR);
    assign prdata  = (paddr[2] == REG_THR) ? r_thr : 32'd0;

    assign o_valid           = r_valid;
    assign o_euclid_distance = r_euc;
    assign o_pearson_corr    = r_pear;
    assign o_cosine_sim      = r_cos;
    assign o_corr_degenerate = r_pflag;
    assign o_cos_degenerate  = r_kflag;

    // bit-pair square root step
    assign sq_sum   = r_res + r_bit;
    assign sq_ge    = (r_w >= sq_sum);
    assign n_sq_w   = sq_ge ? (r_w - sq_sum) : r_w;
    assign n_sq_res = sq_ge ? ((r_res >> 1) + r_bit) : (r_res >> 1);

    // p - q with borrow, and q - p for the negative case
    assign pq_diff = {1'b0, r_p} - {1'b0, r_prod};
    assign qp_diff = r_prod - r_p;
    assign pq_pos  = pq_diff[64] ? 64'd0 : pq_diff[63:0];

    assign k_sum = {1'b0, r_ka} + {1'b0, r_kb};
    assign s_den = STEP_W'(k_sum) + STEP_W'(16);

    // restoring divide step, 65-bit remainder via the top bit
    assign dv_sh   = {r_mag[62:0], 1'b0};
    assign dv_take = r_mag[63] | (dv_sh >= r_den);

    assign q_mag    = {1'b0, r_q};
    assign q_signed = r_neg ? (32'd0 - q_mag) : q_mag;

    // multiplier operand select
    always_comb begin
        mul_en = 1'b0;
        mul_a  = 32'd0;
        mul_b  = 32'd0;
        case (r_state)
            S_ACC: begin
                if (r_step < STEP_W'(4)) begin
                    mul_en = 1'b1;
                    case (r_step[1:0])
                        2'd0: begin
                            mul_a = 32'(r_x);
                            mul_b = 32'(r_y);
                        end
                        2'd1: begin
                            mul_a = 32'(r_x);
                            mul_b = 32'(r_x);
                        end
                        2'd2: begin
                            mul_a = 32'(r_y);
                            mul_b = 32'(r_y);
                        end
                        default: begin
                            mul_a = 32'(r_d);
                            mul_b = 32'(r_d);
                        end
                    endcase
                end
            end
            S_PREP: begin
                if (r_step < STEP_W'(9)) begin
                    mul_en = 1'b1;
                    case (r_step[3:0])
                        4'd0: begin
                            mul_a = 32'(r_cnt);
                            mul_b = r_sxx[31:0];
                        end
                        4'd1: begin
                            mul_a = 32'(r_cnt);
                            mul_b = 32'(r_sxx[55:32]);
                        end
                        4'd2: begin
                            mul_a = r_sx;
                            mul_b = r_sx;
                        end
                        4'd3: begin
                            mul_a = 32'(r_cnt);
                            mul_b = r_syy[31:0];
                        end
                        4'd4: begin
                            mul_a = 32'(r_cnt);
                            mul_b = 32'(r_syy[55:32]);
                        end
                        4'd5: begin
                            mul_a = r_sy;
                            mul_b = r_sy;
                        end
                        4'd6: begin
                            mul_a = 32'(r_cnt);
                            mul_b = r_sxy[31:0];
                        end
                        4'd7: begin
                            mul_a = 32'(r_cnt);
                            mul_b = 32'(r_sxy[55:32]);
                        end
                        default: begin
                            mul_a = r_sx;
                            mul_b = r_sy;
                        end
                    endcase
                end
            end
            S_DEN: begin
                mul_en = 1'b1;
                if (r_step == STEP_W'(0)) begin
                    mul_a = r_sa;
                    mul_b = r_sb;
                end else begin
                    // threshold scaled by the divisor: n for correlation, 1 for cosine
                    mul_a = r_thr;
                    mul_b = r_cos_pass ? 32'd1 : 32'(r_cnt);
                end
            end
            default: begin
                mul_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mul_en) begin
            r_prod <= mul_a * mul_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_RESET;
        end else if (cfg_wr) begin
            r_thr <= pwdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
            r_valid <= 1'b0;
            r_cnt   <= '0;
            r_sx    <= '0;
            r_sy    <= '0;
            r_sxy   <= '0;
            r_sxx   <= '0;
            r_syy   <= '0;
            r_sdd   <= '0;
        end else begin
            r_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_x     <= i_first_value;
                        r_y     <= i_second_value;
                        r_d     <= (i_first_value > i_second_value) ?
                                   (i_first_value - i_second_value) :
                                   (i_second_value - i_first_value);
                        r_last  <= i_last_pair;
                        r_step  <= '0;
                        r_state <= S_ACC;
                    end
                end
                S_ACC: begin
                    r_step <= r_step + STEP_W'(1);
                    case (r_step[2:0])
                        3'd0: begin
                            r_sx  <= r_sx + 32'(r_x);
                            r_sy  <= r_sy + 32'(r_y);
                            r_cnt <= r_cnt + CNT_W'(1);
                        end
                        3'd1: r_sxy <= r_sxy + r_prod[55:0];
                        3'd2: r_sxx <= r_sxx + r_prod[55:0];
                        3'd3: r_syy <= r_syy + r_prod[55:0];
                        default: begin
                            r_sdd  <= r_sdd + r_prod[55:0];
                            r_step <= '0;
                            // full-length vector closes as if flagged last
                            if (r_last || (r_cnt >= CNT_W'(MAX_LEN))) begin
                                r_state <= S_PREP;
                            end else begin
                                r_state <= S_IDLE;
                            end
                        end
                    endcase
                end
                S_PREP: begin
                    // product for step k issues while step k-1 is folded in
                    r_step <= r_step + STEP_W'(1);
                    case (r_step[3:0])
                        4'd1: r_p <= r_prod;
                        4'd2: r_p <= r_p + {r_prod[31:0], 32'd0};
                        4'd3: r_a <= pq_pos;
                        4'd4: r_p <= r_prod;
                        4'd5: r_p <= r_p + {r_prod[31:0], 32'd0};
                        4'd6: r_b <= pq_pos;
                        4'd7: r_p <= r_prod;
                        4'd8: r_p <= r_p + {r_prod[31:0], 32'd0};
                        4'd9: begin
                            r_neg      <= pq_diff[64];
                            r_mag      <= pq_diff[64] ? qp_diff : pq_diff[63:0];
                            r_cos_pass <= 1'b0;
                            r_w        <= 64'(r_sdd);
                            r_res      <= '0;
                            r_bit      <= SQRT_BIT0;
                            r_step     <= '0;
                            r_state    <= S_EUC;
                        end
                        default: r_p <= r_p;
                    endcase
                end
                S_EUC: begin
                    r_w    <= n_sq_w;
                    r_res  <= n_sq_res;
                    r_bit  <= r_bit >> 2;
                    r_step <= r_step + STEP_W'(1);
                    if (r_step == STEP_W'(31)) begin
                        r_euc   <= n_sq_res[27:0];
                        r_state <= S_CHK;
                    end
                end
                S_CHK: begin
                    r_ka <= '0;
                    r_kb <= '0;
                    if ((r_a == 64'd0) || (r_b == 64'd0)) begin
                        r_flag  <= 1'b1;
                        r_q     <= '0;
                        r_state <= S_RDONE;
                    end else begin
                        r_state <= S_NORM_A;
                    end
                end
                S_NORM_A: begin
                    if (r_a[63:62] != 2'b00) begin
                        r_state <= S_NORM_B;
                    end else begin
                        r_a  <= r_a << 2;
                        r_ka <= r_ka + 5'd1;
                    end
                end
                S_NORM_B: begin
                    if (r_b[63:62] != 2'b00) begin
                        r_w     <= r_a;
                        r_res   <= '0;
                        r_bit   <= SQRT_BIT0;
                        r_step  <= '0;
                        r_state <= S_SQRT_A;
                    end else begin
                        r_b  <= r_b << 2;
                        r_kb <= r_kb + 5'd1;
                    end
                end
                S_SQRT_A: begin
                    r_w    <= n_sq_w;
                    r_res  <= n_sq_res;
                    r_bit  <= r_bit >> 2;
                    r_step <= r_step + STEP_W'(1);
                    if (r_step == STEP_W'(31)) begin
                        r_sa    <= n_sq_res[31:0];
                        r_w     <= r_b;
                        r_res   <= '0;
                        r_bit   <= SQRT_BIT0;
                        r_step  <= '0;
                        r_state <= S_SQRT_B;
                    end
                end
                S_SQRT_B: begin
                    r_w    <= n_sq_w;
                    r_res  <= n_sq_res;
                    r_bit  <= r_bit >> 2;
                    r_step <= r_step + STEP_W'(1);
                    if (r_step == STEP_W'(31)) begin
                        r_sb    <= n_sq_res[31:0];
                        r_step  <= '0;
                        r_state <= S_DEN;
                    end
                end
                S_DEN: begin
                    if (r_step == STEP_W'(0)) begin
                        r_step <= STEP_W'(1);
                    end else begin
                        // r_prod now takes the scaled threshold and holds it
                        r_den   <= r_prod;
                        r_w     <= r_prod;
                        r_step  <= '0;
                        r_state <= S_DSHIFT;
                    end
                end
                S_DSHIFT: begin
                    // den's Q16.16 integer part, then compare against threshold * divisor
                    if (r_step == s_den) begin
                        r_step <= '0;
                        r_ovf  <= 1'b0;
                        if (r_w < r_prod) begin
                            r_flag  <= 1'b1;
                            r_q     <= '0;
                            r_state <= S_RDONE;
                        end else begin
                            r_flag  <= 1'b0;
                            r_state <= S_NSHIFT;
                        end
                    end else begin
                        r_w    <= r_w >> 1;
                        r_step <= r_step + STEP_W'(1);
                    end
                end
                S_NSHIFT: begin
                    if (r_step == STEP_W'(k_sum)) begin
                        r_step <= '0;
                        if (r_ovf || (r_mag >= r_den)) begin
                            r_q     <= ONE_Q30;
                            r_state <= S_RDONE;
                        end else begin
                            r_q     <= '0;
                            r_state <= S_DIV;
                        end
                    end else begin
                        r_mag  <= r_mag << 1;
                        r_ovf  <= r_ovf | r_mag[63];
                        r_step <= r_step + STEP_W'(1);
                    end
                end
                S_DIV: begin
                    r_mag  <= dv_take ? (dv_sh - r_den) : dv_sh;
                    r_q    <= {r_q[29:0], dv_take};
                    r_step <= r_step + STEP_W'(1);
                    if (r_step == STEP_W'(29)) begin
                        r_state <= S_RDONE;
                    end
                end
                S_RDONE: begin
                    if (!r_cos_pass) begin
                        r_pear     <= q_signed;
                        r_pflag    <= r_flag;
                        r_a        <= 64'(r_sxx);
                        r_b        <= 64'(r_syy);
                        r_mag      <= 64'(r_sxy);
                        r_neg      <= 1'b0;
                        r_cos_pass <= 1'b1;
                        r_state    <= S_CHK;
                    end else begin
                        r_cos   <= q_signed;
                        r_kflag <= r_flag;
                        r_valid <= 1'b1;
                        r_cnt   <= '0;
                        r_sx    <= '0;
                        r_sy    <= '0;
                        r_sxy   <= '0;
                        r_sxx   <= '0;
                        r_syy   <= '0;
                        r_sdd   <= '0;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
